// ----- src/scti_pkg.sv -----
// Shared constants and sine table functions for the sine/cosine interpolator.
package scti_pkg;

    localparam int TABLE_POINTS         = 361;
    localparam int ROM_FRAC_BITS        = 14;
    localparam int ROM_W                = 24;
    localparam int OUT_W                = 16;
    localparam int DEG_W                = 9;
    localparam int DEFAULT_ANGLE_FRAC   = 16;
    localparam int DEFAULT_OUT_FRAC     = 14;

    localparam logic [14:0] QUARTER [0:90] = '{
            15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
            15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
            15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
            15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
            15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
            15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
            15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
            15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
            15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
            15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
            15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
            15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
            15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
            15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
            15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
            15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
            15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
            15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
            15'd16384};

    // Sine at whole degree k (0..360), folded from the first quadrant and scaled.
    function automatic logic signed [ROM_W-1:0] sin_entry(input logic [DEG_W-1:0] k,
                                                          input int ofb);
        logic [DEG_W-1:0] idx;
        logic neg;
        logic signed [ROM_W-1:0] v;
        if (k <= 9'd90) begin
            idx = k;
            neg = 1'b0;
        end else if (k <= 9'd180) begin
            idx = 9'd180 - k;
            neg = 1'b0;
        end else if (k <= 9'd270) begin
            idx = k - 9'd180;
            neg = 1'b1;
        end else begin
            idx = 9'd360 - k;
            neg = 1'b1;
        end
        v = ROM_W'(signed'({1'b0, QUARTER[idx[6:0]]}));
        if (neg)
            v = -v;
        if (ofb < ROM_FRAC_BITS)
            v = (v + ROM_W'(1 << (ROM_FRAC_BITS - ofb - 1))) >>> (ROM_FRAC_BITS - ofb);
        else
            v = v <<< (ofb - ROM_FRAC_BITS);
        return v;
    endfunction

    function automatic logic signed [ROM_W-1:0] cos_entry(input logic [DEG_W-1:0] k,
                                                          input int ofb);
        logic [DEG_W-1:0] j;
        j = (k >= 9'd270) ? k - 9'd270 : k + 9'd90;
        return sin_entry(j, ofb);
    endfunction

endpackage

// ----- src/sine_cosine_table_interpolator_unit.sv -----
// A six-stage pipeline with a shared clock enable.
// Throughput: one angle per cycle while the output is not stalled.
// Stages: biasing, reciprocal multiply, remainder, table lookup, multiply, add.
// A stall on the output freezes every stage, so nothing is lost or repeated.
// Reset clears the valid bits of all stages; the data registers are not reset.
module sine_cosine_table_interpolator_unit #(
    parameter int ANGLE_FRAC_BITS = scti_pkg::DEFAULT_ANGLE_FRAC,
    parameter int OUT_FRAC_BITS   = scti_pkg::DEFAULT_OUT_FRAC
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] angle_deg
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [15:0] sine_value, [31:16] cosine_value
);

    logic                            ce;
    logic                            red_valid;
    logic [scti_pkg::DEG_W-1:0]      deg;
    logic [ANGLE_FRAC_BITS-1:0]      frac;
    logic [scti_pkg::OUT_W-1:0]      sine, cosine;

    // The pipeline moves whenever the output register is empty or being drained.
    assign ce            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = ce;

    scti_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_axis_tvalid),
        .angle     (s_axis_tdata),
        .out_valid (red_valid),
        .deg       (deg),
        .frac      (frac)
    );

    scti_interp #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS)
    ) u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (red_valid),
        .deg       (deg),
        .frac      (frac),
        .out_valid (m_axis_tvalid),
        .sine      (sine),
        .cosine    (cosine)
    );

    assign m_axis_tdata = {cosine, sine};

endmodule

// ----- src/scti_reduce.sv -----
// Three-stage reduction of the angle to a whole degree 0..359 and a fraction.
module scti_reduce #(
    parameter int ANGLE_FRAC_BITS = scti_pkg::DEFAULT_ANGLE_FRAC
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic [31:0]                     angle,
    output logic                            out_valid,
    output logic [scti_pkg::DEG_W-1:0]      deg,
    output logic [ANGLE_FRAC_BITS-1:0]      frac
);

    localparam int IW     = 32 - ANGLE_FRAC_BITS;
    localparam int UW     = IW + 1;
    localparam int MW     = UW - 8;
    localparam int OFFSET = 360 * ((2 ** (IW - 1) + 359) / 360);
    localparam logic [MW-1:0] RECIP = MW'((2 ** UW) / 360);

    logic [2:0]                 v_reg;
    logic [UW-1:0]              u1_reg, u2_reg;
    logic [MW-1:0]              q_reg;
    logic [ANGLE_FRAC_BITS-1:0] f1_reg, f2_reg, f3_reg;
    logic [scti_pkg::DEG_W-1:0] deg_reg;
    logic [UW-1:0]              u_next;
    logic [UW+MW-1:0]           prod;
    logic [UW-1:0]              rem;
    logic [UW-1:0]              rem_fix;

    // Biasing by a multiple of 360 makes the integer degree non-negative.
    assign u_next  = UW'(signed'(angle[31:ANGLE_FRAC_BITS])) + UW'(OFFSET);
    assign prod    = (UW+MW)'(u1_reg) * (UW+MW)'(RECIP);
    // The reciprocal quotient is low by at most one, so one correction suffices.
    assign rem     = u2_reg - UW'(q_reg * UW'(360));
    assign rem_fix = (rem >= UW'(360)) ? rem - UW'(360) : rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (ce)
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            u1_reg  <= u_next;
            f1_reg  <= angle[ANGLE_FRAC_BITS-1:0];
            q_reg   <= prod[UW+MW-1:UW];
            u2_reg  <= u1_reg;
            f2_reg  <= f1_reg;
            deg_reg <= rem_fix[scti_pkg::DEG_W-1:0];
            f3_reg  <= f2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign deg       = deg_reg;
    assign frac      = f3_reg;

endmodule

// ----- src/scti_interp.sv -----
// Three-stage table lookup and linear interpolation of sine and cosine.
module scti_interp #(
    parameter int ANGLE_FRAC_BITS = scti_pkg::DEFAULT_ANGLE_FRAC,
    parameter int OUT_FRAC_BITS   = scti_pkg::DEFAULT_OUT_FRAC
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic [scti_pkg::DEG_W-1:0]      deg,
    input  logic [ANGLE_FRAC_BITS-1:0]      frac,
    output logic                            out_valid,
    output logic [scti_pkg::OUT_W-1:0]      sine,
    output logic [scti_pkg::OUT_W-1:0]      cosine
);

    localparam int RW = scti_pkg::ROM_W;
    localparam int PW = RW + ANGLE_FRAC_BITS + 1;

    logic [2:0]                 v_reg;
    logic signed [RW-1:0]       s0_reg, s1_reg, c0_reg, c1_reg, s0b_reg, c0b_reg;
    logic [ANGLE_FRAC_BITS-1:0] f_reg;
    logic signed [PW-1:0]       sp_reg, cp_reg;
    logic [scti_pkg::OUT_W-1:0] sine_reg, cosine_reg;
    logic [scti_pkg::DEG_W-1:0] deg1;
    logic signed [PW-1:0]       sp_next, cp_next, sum_s, sum_c;

    assign deg1    = deg + 9'd1;
    assign sp_next = signed'(PW'({1'b0, f_reg})) * PW'(s1_reg - s0_reg);
    assign cp_next = signed'(PW'({1'b0, f_reg})) * PW'(c1_reg - c0_reg);
    assign sum_s   = PW'(s0b_reg) + (sp_reg >>> ANGLE_FRAC_BITS);
    assign sum_c   = PW'(c0b_reg) + (cp_reg >>> ANGLE_FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (ce)
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s0_reg     <= scti_pkg::sin_entry(deg, OUT_FRAC_BITS);
            s1_reg     <= scti_pkg::sin_entry(deg1, OUT_FRAC_BITS);
            c0_reg     <= scti_pkg::cos_entry(deg, OUT_FRAC_BITS);
            c1_reg     <= scti_pkg::cos_entry(deg1, OUT_FRAC_BITS);
            f_reg      <= frac;
            sp_reg     <= sp_next;
            cp_reg     <= cp_next;
            s0b_reg    <= s0_reg;
            c0b_reg    <= c0_reg;
            sine_reg   <= sum_s[scti_pkg::OUT_W-1:0];
            cosine_reg <= sum_c[scti_pkg::OUT_W-1:0];
        end
    end

    assign out_valid = v_reg[2];
    assign sine      = sine_reg;
    assign cosine    = cosine_reg;

endmodule

// ----- src/scti_checker.sv -----
// Port-level assertions for the sine/cosine interpolator, bound to the top level.
module scti_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output register is empty");

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is drained");

    a_result_after_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(in_acc, 6) && $past(s_axis_tready, 5) && $past(s_axis_tready, 4)
         && $past(s_axis_tready, 3) && $past(s_axis_tready, 2)
         && $past(s_axis_tready, 1)) |-> m_axis_tvalid)
        else $error("accepted angle produced no result after six cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind sine_cosine_table_interpolator_unit scti_checker u_scti_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
